@@ rtl/pqfs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pqfs_pkg;

	localparam int NUM_SLOTS        = 32;
	localparam int SLOT_W           = 5;
	localparam int TAB_ENTRIES      = 16;
	localparam int CODE_BYTES       = 16;
	localparam int DEFAULT_SUM_BITS = 32;
	localparam int OUT_SUM_BITS     = 32;
	localparam int QUEUE_DEPTH      = 4;
	localparam int QPTR_W           = 2;

	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] addend;
		logic                      last;
	} pqfs_item_t;

endpackage
`default_nettype wire

@@ rtl/pqfs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pqfs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          table_low,
	input  logic [63:0]          table_high,
	input  logic [63:0]          codes_low,
	input  logic [63:0]          codes_high,
	input  logic                 last_subquantizer,
	output logic                 item_valid,
	output pqfs_pkg::pqfs_item_t item,
	input  logic                 item_ready
);
	import pqfs_pkg::*;

	logic [TAB_ENTRIES-1:0][7:0] tab;
	logic [CODE_BYTES-1:0][7:0]  code;
	pqfs_item_t                  lookup;
	logic                        item_valid_s1;
	pqfs_item_t                  item_s1;

	assign tab  = {table_high, table_low};
	assign code = {codes_high, codes_low};

	// Even code bytes feed slots 0..7 and 16..23, odd bytes slots 8..15 and 24..31.
	always_comb begin
		lookup.last = last_subquantizer;
		lookup.addend = '0;
		for (int j = 0; j < CODE_BYTES; j++) begin
			lookup.addend[SLOT_W'((j % 2) * 8 + j / 2)]      = tab[code[4'(j)][3:0]];
			lookup.addend[SLOT_W'((j % 2) * 8 + j / 2 + 16)] = tab[code[4'(j)][7:4]];
		end
	end

	assign in_ready   = !item_valid_s1 || item_ready;
	assign item_valid = item_valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= lookup;
		end
	end

endmodule
`default_nettype wire

@@ rtl/pqfs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pqfs_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  pqfs_pkg::pqfs_item_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output pqfs_pkg::pqfs_item_t pop_data
);
	import pqfs_pkg::*;

	pqfs_item_t          entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ rtl/pqfs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pqfs_back #(
	parameter int SUM_BITS = pqfs_pkg::DEFAULT_SUM_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  pqfs_pkg::pqfs_item_t                item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [pqfs_pkg::SLOT_W-1:0]         vector_slot,
	output logic [pqfs_pkg::OUT_SUM_BITS-1:0]   distance_sum,
	output logic                                last_of_run
);
	import pqfs_pkg::*;

	logic [NUM_SLOTS-1:0][SUM_BITS-1:0] acc_q;
	logic [NUM_SLOTS-1:0][SUM_BITS-1:0] snap_q;
	logic [NUM_SLOTS-1:0][SUM_BITS-1:0] sum_c;
	logic [NUM_SLOTS-1:0][SUM_BITS:0]   wide_c;
	logic                               drain_busy_q;
	logic [SLOT_W-1:0]                  drain_idx_q;
	logic                               idx_last;
	logic                               final_beat;
	logic                               item_fire;

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			wide_c[i] = {1'b0, acc_q[i]} + (SUM_BITS+1)'(item.addend[i]);
			sum_c[i]  = wide_c[i][SUM_BITS] ? {SUM_BITS{1'b1}} : wide_c[i][SUM_BITS-1:0];
		end
	end

	assign idx_last   = drain_idx_q == SLOT_W'(NUM_SLOTS - 1);
	assign final_beat = drain_busy_q && out_ready && idx_last;
	// A closing item needs the drain buffer, which frees up on the final beat.
	assign item_ready = !item.last || !drain_busy_q || final_beat;
	assign item_fire  = item_valid && item_ready;

	assign out_valid    = drain_busy_q;
	assign vector_slot  = drain_idx_q;
	assign distance_sum = OUT_SUM_BITS'(snap_q[drain_idx_q]);
	assign last_of_run  = idx_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			drain_busy_q <= 1'b0;
			drain_idx_q  <= '0;
		end else begin
			if (item_fire) begin
				acc_q <= item.last ? '0 : sum_c;
			end
			if (item_fire && item.last) begin
				drain_busy_q <= 1'b1;
				drain_idx_q  <= '0;
			end else if (drain_busy_q && out_ready) begin
				drain_busy_q <= !idx_last;
				drain_idx_q  <= drain_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire && item.last) begin
			snap_q <= sum_c;
		end
	end

`ifndef ASSERT_OFF
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && item.last |=> acc_q == '0)
		else $error("accumulators not cleared after closing item");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && item.last && drain_busy_q |-> out_ready && idx_last)
		else $error("closing item accepted while drain buffer is busy");

	a_drain_start: assert property (@(posedge clk) disable iff (!arst_n)
		item_fire && item.last |=> drain_busy_q && drain_idx_q == '0)
		else $error("drain did not restart at slot zero");
`endif

endmodule
`default_nettype wire

@@ rtl/pq_fast_scan_lookup_accumulate.sv @@
// A last beat goes through the front register and the queue into the drain buffer.
// Throughput: one input beat per cycle while the queue has room, set by the table lookup stage and the 32 adders.
// Each closing beat yields 32 result beats, one per cycle from the drain buffer while out_ready is high.
// Runs shorter than 32 beats can stall the input until the previous drain frees the buffer.
// Reset clears all accumulators, empties the queue and cancels any drain in progress.
`timescale 1ns / 1ps
`default_nettype none
module pq_fast_scan_lookup_accumulate #(
	parameter int SUM_BITS = pqfs_pkg::DEFAULT_SUM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [63:0]                       table_low,
	input  logic [63:0]                       table_high,
	input  logic [63:0]                       codes_low,
	input  logic [63:0]                       codes_high,
	input  logic                              last_subquantizer,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pqfs_pkg::SLOT_W-1:0]       vector_slot,
	output logic [pqfs_pkg::OUT_SUM_BITS-1:0] distance_sum,
	output logic                              last_of_run
);
	import pqfs_pkg::*;

	logic       front_valid;
	logic       front_ready;
	pqfs_item_t front_item;
	logic       back_valid;
	logic       back_ready;
	pqfs_item_t back_item;

	pqfs_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.table_low         (table_low),
		.table_high        (table_high),
		.codes_low         (codes_low),
		.codes_high        (codes_high),
		.last_subquantizer (last_subquantizer),
		.item_valid        (front_valid),
		.item              (front_item),
		.item_ready        (front_ready)
	);

	pqfs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_item)
	);

	pqfs_back #(
		.SUM_BITS (SUM_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (back_valid),
		.item_ready   (back_ready),
		.item         (back_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vector_slot  (vector_slot),
		.distance_sum (distance_sum),
		.last_of_run  (last_of_run)
	);

endmodule
`default_nettype wire

@@ dv/tb_pq_fast_scan_lookup_accumulate.sv @@
`timescale 1ns / 1ps
module tb_pq_fast_scan_lookup_accumulate;

	localparam int SUM_W = pqfs_pkg::DEFAULT_SUM_BITS;
	localparam logic [32:0] SUM_MAX = (33'd1 << SUM_W) - 33'd1;
	localparam int STALL_LIMIT = 3000;

	typedef struct packed {
		logic [pqfs_pkg::SLOT_W-1:0]       slot;
		logic [pqfs_pkg::OUT_SUM_BITS-1:0] dsum;
		logic                              tail;
	} sum_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [63:0] table_low = '0;
	logic [63:0] table_high = '0;
	logic [63:0] codes_low = '0;
	logic [63:0] codes_high = '0;
	logic last_subquantizer = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pqfs_pkg::SLOT_W-1:0] vector_slot;
	logic [pqfs_pkg::OUT_SUM_BITS-1:0] distance_sum;
	logic last_of_run;

	logic [31:0] slot_acc [pqfs_pkg::NUM_SLOTS];
	sum_beat_t expected_sums [$];

	int beats_in = 0;
	int runs_closed = 0;
	int sums_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int stall_run = 0;
	int longest_stall = 0;
	bit send_idle = 1'b0;
	bit rx_stalls = 1'b0;
	int hold_len = 0;
	int hold_seq = 0;

	pq_fast_scan_lookup_accumulate #(
		.SUM_BITS(SUM_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.table_low(table_low),
		.table_high(table_high),
		.codes_low(codes_low),
		.codes_high(codes_high),
		.last_subquantizer(last_subquantizer),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vector_slot(vector_slot),
		.distance_sum(distance_sum),
		.last_of_run(last_of_run)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [7:0] table_byte(input logic [63:0] tl, input logic [63:0] th,
			input logic [3:0] idx);
		logic [63:0] half;
		half = idx[3] ? th : tl;
		return half[idx[2:0] * 8 +: 8];
	endfunction

	task automatic add_saturating(input logic [4:0] slot, input logic [7:0] addend);
		logic [32:0] wide;
		wide = {1'b0, slot_acc[slot]} + 33'(addend);
		if (wide > SUM_MAX) begin
			wide = SUM_MAX;
		end
		slot_acc[slot] = wide[31:0];
	endtask

	task automatic predict_beat(input logic [63:0] tl, input logic [63:0] th,
			input logic [63:0] cl, input logic [63:0] ch, input logic closes);
		logic [7:0] cbyte;
		logic [4:0] lo_slot;
		for (int j = 0; j < pqfs_pkg::CODE_BYTES; j++) begin
			cbyte = (j < 8) ? cl[j * 8 +: 8] : ch[(j - 8) * 8 +: 8];
			lo_slot = (j % 2 == 0) ? 5'(j / 2) : 5'(8 + j / 2);
			add_saturating(lo_slot, table_byte(tl, th, cbyte[3:0]));
			add_saturating(lo_slot + 5'd16, table_byte(tl, th, cbyte[7:4]));
		end
		if (closes) begin
			for (int s = 0; s < pqfs_pkg::NUM_SLOTS; s++) begin
				expected_sums.push_back('{slot: 5'(s), dsum: slot_acc[s],
					tail: (s == pqfs_pkg::NUM_SLOTS - 1)});
				slot_acc[s] = '0;
			end
			runs_closed++;
		end
	endtask

	// Called at a rising edge; returns at the edge where the beat is accepted.
	task automatic send_beat(input logic [63:0] tl, input logic [63:0] th,
			input logic [63:0] cl, input logic [63:0] ch, input logic closes);
		int gap;
		if (send_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		table_low <= tl;
		table_high <= th;
		codes_low <= cl;
		codes_high <= ch;
		last_subquantizer <= closes;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		beats_in++;
		predict_beat(tl, th, cl, ch, closes);
	endtask

	task automatic send_random_run(input int len);
		for (int i = 0; i < len; i++) begin
			send_beat(rand64(), rand64(), rand64(), rand64(), i == len - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_sums.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_beat('0, '0, '0, '0, 1'b1);
		send_beat('1, '1, '1, '1, 1'b1);
		send_beat(64'hFF, '0, '0, '0, 1'b0);
		send_beat('0, 64'hFF00000000000000, '1, '1, 1'b1);
		// Distinct table entries with each nibble value placed once per byte position.
		send_beat(64'h7766554433221100, 64'hFFEEDDCCBBAA9988,
			64'h8796A5B4C3D2E1F0, 64'h0F1E2D3C4B5A6978, 1'b0);
		send_beat(64'h7766554433221100, 64'hFFEEDDCCBBAA9988,
			64'h78695A4B3C2D1E0F, 64'hF0E1D2C3B4A59687, 1'b0);
		send_beat(64'h0123456789ABCDEF, 64'hFEDCBA9876543210,
			64'h00FF00FF00FF00FF, 64'hFF00FF00FF00FF00, 1'b1);
		for (int i = 0; i < 4; i++) begin
			send_random_run(1);
		end
		send_random_run(2);
	endtask

	task automatic test_random_runs(input int beats);
		int sent;
		int len;
		sent = 0;
		while (sent < beats) begin
			len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			send_random_run(len);
			sent += len;
		end
	endtask

	task automatic test_receiver_hold();
		hold_len = 400;
		hold_seq++;
		for (int i = 0; i < 10; i++) begin
			send_random_run(1);
		end
		send_random_run(20);
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 3; i++) begin
			send_random_run($urandom_range(1, 12));
			wait_drained();
		end
	endtask

	task automatic test_long_run(input int len);
		logic [63:0] tl;
		logic [63:0] th;
		for (int i = 0; i < len; i++) begin
			for (int k = 0; k < 8; k++) begin
				tl[k * 8 +: 8] = 8'($urandom_range(8'hC0, 8'hFF));
				th[k * 8 +: 8] = 8'($urandom_range(8'hC0, 8'hFF));
			end
			send_beat(tl, th, rand64(), rand64(), i == len - 1);
		end
	endtask

	initial begin : rx_ready_drive
		int seen;
		int quiet;
		int burst;
		seen = 0;
		quiet = 0;
		burst = 0;
		forever begin
			@(posedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				quiet = hold_len;
			end
			if (quiet > 0) begin
				out_ready <= 1'b0;
				quiet--;
			end else if (burst > 0) begin
				out_ready <= 1'b0;
				burst--;
			end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				burst = $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : sum_check
		sum_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_sums.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected sum beat: slot %0d sum %0d last %0b",
						vector_slot, distance_sum, last_of_run);
				end
			end else begin
				want = expected_sums.pop_front();
				sums_checked++;
				if (vector_slot !== want.slot || distance_sum !== want.dsum ||
						last_of_run !== want.tail) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Sum beat mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
							want.slot, want.dsum, want.tail,
							vector_slot, distance_sum, last_of_run);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (in_valid && in_ready !== 1'b1) begin
			stall_run <= stall_run + 1;
			if (stall_run + 1 > longest_stall) begin
				longest_stall <= stall_run + 1;
			end
		end else begin
			stall_run <= 0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("[pq_fast_scan_lookup_accumulate] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		for (int s = 0; s < pqfs_pkg::NUM_SLOTS; s++) begin
			slot_acc[s] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		send_idle = 1'b1;
		rx_stalls = 1'b1;
		test_random_runs(150);
		test_receiver_hold();
		test_drain_pause();
		test_long_run(260);
		send_idle = 1'b0;
		rx_stalls = 1'b0;
		test_random_runs(40);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Accepted %0d input beats closing %0d runs; checked %0d sum beats.",
			beats_in, runs_closed, sums_checked);
		$display("Longest input stall %0d cycles, with a receiver hold-off and drain pauses.",
			longest_stall);
		if (mismatches == 0 && expected_sums.size() == 0) begin
			$display("[pq_fast_scan_lookup_accumulate] OK");
		end else begin
			$display("[pq_fast_scan_lookup_accumulate] ERROR");
		end
		$finish;
	end

endmodule
